// File: rtl/core/gww_pkg.sv
package gww_pkg;

    localparam int CHAR_W     = 8;
    localparam int LIMIT_W    = 16;
    localparam int PIX_W      = 17;
    localparam int RESULT_CAP = 36;
    localparam int EMIT_CNT_W = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PIX_W-1:0]   PIX_MAX     = '1;
    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd640;

    typedef logic [1:0] cls_t;

    localparam cls_t CLS_LOAD    = 2'd0;
    localparam cls_t CLS_NEWLINE = 2'd1;
    localparam cls_t CLS_SPACE   = 2'd2;
    localparam cls_t CLS_OTHER   = 2'd3;

    typedef struct packed {
        cls_t              cls;
        logic [CHAR_W-1:0] char_code;
        logic [CHAR_W-1:0] glyph_width;
        logic              end_of_text;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    function automatic logic [PIX_W-1:0] sum_sat(
        input logic [PIX_W-1:0]  a,
        input logic [CHAR_W-1:0] b
    );
        logic [PIX_W:0] s;
        s = {1'b0, a} + {{(PIX_W + 1 - CHAR_W){1'b0}}, b};
        sum_sat = s[PIX_W] ? PIX_MAX : s[PIX_W-1:0];
    endfunction

endpackage

// File: rtl/core/gww_channels.sv
interface gww_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_code;
    logic [7:0] glyph_width;
    logic       end_of_text;

    modport source (output valid, cmd, char_code, glyph_width, end_of_text, input ready);
    modport sink (input valid, cmd, char_code, glyph_width, end_of_text, output ready);
endinterface

interface gww_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       text_end;
    logic       run_last;

    modport source (output valid, out_char, text_end, run_last, input ready);
    modport sink (input valid, out_char, text_end, run_last, output ready);
endinterface

interface gww_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] line_limit;

    modport source (output valid, line_limit, input ready);
    modport sink (input valid, line_limit, output ready);
endinterface

// File: rtl/core/greedy_word_wrap_core.sv
// Greedy word wrap core.
// text_in: one beat per item. cmd 0 loads glyph_width into the width table at
//   char_code and gives no result; cmd 1 passes a text character.
// text_out: one beat per emitted byte; run_last marks the last beat of an
//   item, text_end that of an item with end_of_text set.
// cfg: writes line_limit; always ready. It is to be written only while the
//   core is idle; the core itself does not enforce this.
// A two-entry queue decouples intake from the wrap sequencer, so intake keeps
//   going while the sequencer or output stalls, until both entries are full.
// Sequencer steps: a load uses S_IDLE alone; a character that only grows the
//   word passes S_GLYPH, S_OTHER_CHK, S_EOT_CHK and S_FINISH; a byte flushed
//   from the word buffer adds S_FL_READ and S_FL_EMIT, a byte replayed after a
//   break S_RP_READ, S_RP_GLYPH and S_RP_EMIT (buffer read, width read, add).
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the queue, line count, held word and pending space, and sets
//   line_limit to 640; the width table holds nothing until loaded.
module greedy_word_wrap_core #(
    parameter int WORD_BUFFER_DEPTH = 32,
    parameter int GLYPH_COUNT       = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    gww_in_if.sink      text_in,
    gww_out_if.source   text_out,
    gww_cfg_if.sink     cfg
);

    gww_pkg::queue_head_t head;
    logic                 pop;

    gww_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .head    (head),
        .pop     (pop)
    );

    gww_back #(
        .WORD_BUFFER_DEPTH (WORD_BUFFER_DEPTH),
        .GLYPH_COUNT       (GLYPH_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .cfg      (cfg),
        .text_out (text_out)
    );

endmodule

// File: rtl/core/gww_front.sv
module gww_front (
    input  logic                   clk,
    input  logic                   rst_n,
    gww_in_if.sink                 text_in,
    output gww_pkg::queue_head_t   head,
    input  logic                   pop
);

    localparam int PTR_W = $clog2(gww_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(gww_pkg::QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   FILL_MAX = (PTR_W + 1)'(gww_pkg::QUEUE_DEPTH);

    gww_pkg::item_t    slot_reg [gww_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    fill_reg;
    gww_pkg::item_t    item_in;
    logic              push;

    always_comb
    begin
        item_in.char_code   = text_in.char_code;
        item_in.glyph_width = text_in.glyph_width;
        item_in.end_of_text = text_in.end_of_text;
        if (!text_in.cmd)
        begin
            item_in.cls = gww_pkg::CLS_LOAD;
        end
        else if (text_in.char_code == gww_pkg::CH_NEWLINE)
        begin
            item_in.cls = gww_pkg::CLS_NEWLINE;
        end
        else if (text_in.char_code == gww_pkg::CH_SPACE)
        begin
            item_in.cls = gww_pkg::CLS_SPACE;
        end
        else
        begin
            item_in.cls = gww_pkg::CLS_OTHER;
        end
    end

    assign text_in.ready = (fill_reg != FILL_MAX);
    assign push          = text_in.valid && text_in.ready;
    assign head.valid    = (fill_reg != '0);
    assign head.item     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: rtl/core/gww_back.sv
module gww_back #(
    parameter int WORD_BUFFER_DEPTH = 32,
    parameter int GLYPH_COUNT       = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gww_pkg::queue_head_t  head,
    output logic                  pop,
    gww_cfg_if.sink               cfg,
    gww_out_if.source             text_out
);

    localparam int BUF_IDX_W   = $clog2(WORD_BUFFER_DEPTH);
    localparam int BUF_CNT_W   = $clog2(WORD_BUFFER_DEPTH + 1);
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam logic [BUF_CNT_W-1:0] BUF_FULL  = BUF_CNT_W'(WORD_BUFFER_DEPTH);
    localparam logic [8:0]           GLYPH_END = 9'(GLYPH_COUNT);
    localparam logic [gww_pkg::EMIT_CNT_W-1:0] EMIT_CAP =
        gww_pkg::EMIT_CNT_W'(gww_pkg::RESULT_CAP);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_GLYPH      = 4'd1;
    localparam logic [3:0] S_FL_SPACE   = 4'd2;
    localparam logic [3:0] S_FL_READ    = 4'd3;
    localparam logic [3:0] S_FL_EMIT    = 4'd4;
    localparam logic [3:0] S_NL_EMIT    = 4'd5;
    localparam logic [3:0] S_SPACE_ADD  = 4'd6;
    localparam logic [3:0] S_OTHER_CHK  = 4'd7;
    localparam logic [3:0] S_BREAK_NL   = 4'd8;
    localparam logic [3:0] S_RP_READ    = 4'd9;
    localparam logic [3:0] S_RP_GLYPH   = 4'd10;
    localparam logic [3:0] S_RP_EMIT    = 4'd11;
    localparam logic [3:0] S_PLACE      = 4'd12;
    localparam logic [3:0] S_PLACE_EMIT = 4'd13;
    localparam logic [3:0] S_EOT_CHK    = 4'd14;
    localparam logic [3:0] S_FINISH     = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;
    logic [gww_pkg::PIX_W-1:0]   lp_reg, lp_next;
    logic [BUF_CNT_W-1:0]        cnt_reg, cnt_next;
    logic [BUF_CNT_W-1:0]        k_reg, k_next;
    logic                        sp_reg, sp_next;
    logic [7:0]                  cw_reg, cw_next;
    logic [gww_pkg::LIMIT_W-1:0] limit_reg;

    logic [7:0]        cur_char_reg;
    logic              cur_eot_reg;
    gww_pkg::cls_t     cur_cls_reg;

    logic [7:0] glyph_mem [GLYPH_COUNT];
    logic [7:0] gl_q_reg;
    logic       gl_oob_reg;
    logic       gl_we, gl_re;
    logic [7:0] gl_addr;
    logic [7:0] gl_w;

    logic [7:0] buf_mem [WORD_BUFFER_DEPTH];
    logic [7:0] buf_q_reg;
    logic       buf_we, buf_re;

    logic                            hold_valid_reg;
    logic [7:0]                      hold_char_reg;
    logic [gww_pkg::EMIT_CNT_W-1:0]  emit_cnt_reg;
    logic                            out_valid_reg;
    logic [7:0]                      out_char_reg;
    logic                            out_end_reg;
    logic                            out_last_reg;

    logic       out_free, drop, emit_ok, finish_ok;
    logic       emit_req, finish, load_out;
    logic [7:0] emit_char;
    logic [gww_pkg::PIX_W-1:0] lp_sum;
    logic       over;

    assign gl_w      = gl_oob_reg ? 8'd0 : gl_q_reg;
    assign out_free  = !out_valid_reg || text_out.ready;
    assign drop      = (emit_cnt_reg >= EMIT_CAP);
    assign emit_ok   = drop || !hold_valid_reg || out_free;
    assign finish_ok = !hold_valid_reg || out_free;
    assign lp_sum    = gww_pkg::sum_sat(lp_reg, cw_reg);
    assign over      = (lp_sum > {1'b0, limit_reg});
    assign load_out  = hold_valid_reg && ((emit_req && !drop) || finish);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        lp_next    = lp_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        sp_next    = sp_reg;
        cw_next    = cw_reg;
        pop        = 1'b0;
        emit_req   = 1'b0;
        emit_char  = gww_pkg::CH_NEWLINE;
        finish     = 1'b0;
        gl_we      = 1'b0;
        gl_re      = 1'b0;
        gl_addr    = head.item.char_code;
        buf_we     = 1'b0;
        buf_re     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.cls == gww_pkg::CLS_LOAD)
                    begin
                        gl_we = ({1'b0, head.item.char_code} < GLYPH_END);
                    end
                    else
                    begin
                        gl_re      = 1'b1;
                        state_next = S_GLYPH;
                    end
                end
            end
            S_GLYPH:
            begin
                cw_next = gl_w;
                case (cur_cls_reg)
                    gww_pkg::CLS_NEWLINE:
                    begin
                        ret_next   = S_NL_EMIT;
                        state_next = S_FL_SPACE;
                    end
                    gww_pkg::CLS_SPACE:
                    begin
                        ret_next   = S_SPACE_ADD;
                        state_next = S_FL_SPACE;
                    end
                    default:
                    begin
                        if (sp_reg && cnt_reg >= BUF_FULL)
                        begin
                            ret_next   = S_OTHER_CHK;
                            state_next = S_FL_SPACE;
                        end
                        else
                        begin
                            state_next = S_OTHER_CHK;
                        end
                    end
                endcase
            end
            S_FL_SPACE:
            begin
                if (!sp_reg)
                begin
                    k_next     = '0;
                    state_next = S_FL_READ;
                end
                else if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    emit_char  = gww_pkg::CH_SPACE;
                    sp_next    = 1'b0;
                    k_next     = '0;
                    state_next = S_FL_READ;
                end
            end
            S_FL_READ:
            begin
                if (k_reg < cnt_reg)
                begin
                    buf_re     = 1'b1;
                    state_next = S_FL_EMIT;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
            end
            S_FL_EMIT:
            begin
                if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    emit_char  = buf_q_reg;
                    k_next     = k_reg + 1'b1;
                    state_next = S_FL_READ;
                end
            end
            S_NL_EMIT:
            begin
                if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    lp_next    = '0;
                    state_next = S_EOT_CHK;
                end
            end
            S_SPACE_ADD:
            begin
                if (over)
                begin
                    if (emit_ok)
                    begin
                        emit_req   = 1'b1;
                        lp_next    = '0;
                        state_next = S_EOT_CHK;
                    end
                end
                else
                begin
                    lp_next    = lp_sum;
                    sp_next    = 1'b1;
                    state_next = S_EOT_CHK;
                end
            end
            S_OTHER_CHK:
            begin
                if (!sp_reg)
                begin
                    state_next = S_PLACE;
                end
                else if (!over)
                begin
                    buf_we     = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    lp_next    = lp_sum;
                    state_next = S_EOT_CHK;
                end
                else
                begin
                    state_next = S_BREAK_NL;
                end
            end
            S_BREAK_NL:
            begin
                if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    lp_next    = '0;
                    k_next     = '0;
                    state_next = S_RP_READ;
                end
            end
            S_RP_READ:
            begin
                if (k_reg < cnt_reg)
                begin
                    buf_re     = 1'b1;
                    state_next = S_RP_GLYPH;
                end
                else
                begin
                    cnt_next   = '0;
                    sp_next    = 1'b0;
                    state_next = S_PLACE;
                end
            end
            S_RP_GLYPH:
            begin
                gl_re      = 1'b1;
                gl_addr    = buf_q_reg;
                state_next = S_RP_EMIT;
            end
            S_RP_EMIT:
            begin
                if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    emit_char  = buf_q_reg;
                    lp_next    = gww_pkg::sum_sat(lp_reg, gl_w);
                    k_next     = k_reg + 1'b1;
                    state_next = S_RP_READ;
                end
            end
            S_PLACE:
            begin
                if (lp_reg != '0 && over)
                begin
                    if (emit_ok)
                    begin
                        emit_req   = 1'b1;
                        lp_next    = '0;
                        state_next = S_PLACE_EMIT;
                    end
                end
                else
                begin
                    state_next = S_PLACE_EMIT;
                end
            end
            S_PLACE_EMIT:
            begin
                if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    emit_char  = cur_char_reg;
                    lp_next    = lp_sum;
                    state_next = S_EOT_CHK;
                end
            end
            S_EOT_CHK:
            begin
                if (cur_eot_reg)
                begin
                    ret_next   = S_FINISH;
                    state_next = S_FL_SPACE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (finish_ok)
                begin
                    finish = 1'b1;
                    if (cur_eot_reg)
                    begin
                        lp_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg.ready         = 1'b1;
    assign text_out.valid    = out_valid_reg;
    assign text_out.out_char = out_char_reg;
    assign text_out.text_end = out_end_reg;
    assign text_out.run_last = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            lp_reg         <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            sp_reg         <= 1'b0;
            cw_reg         <= '0;
            limit_reg      <= gww_pkg::LIMIT_RESET;
            hold_valid_reg <= 1'b0;
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            lp_reg    <= lp_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            sp_reg    <= sp_next;
            cw_reg    <= cw_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.line_limit;
            end
            if (finish)
            begin
                hold_valid_reg <= 1'b0;
                emit_cnt_reg   <= '0;
            end
            else if (emit_req && !drop)
            begin
                hold_valid_reg <= 1'b1;
                emit_cnt_reg   <= emit_cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_char_reg <= head.item.char_code;
            cur_eot_reg  <= head.item.end_of_text;
            cur_cls_reg  <= head.item.cls;
        end
        if (emit_req && !drop)
        begin
            hold_char_reg <= emit_char;
        end
        if (load_out)
        begin
            out_char_reg <= hold_char_reg;
            out_end_reg  <= finish && cur_eot_reg;
            out_last_reg <= finish;
        end
    end

    // glyph width table: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (gl_we)
        begin
            glyph_mem[head.item.char_code[GLYPH_IDX_W-1:0]] <= head.item.glyph_width;
        end
        if (gl_re)
        begin
            gl_q_reg   <= glyph_mem[gl_addr[GLYPH_IDX_W-1:0]];
            gl_oob_reg <= ({1'b0, gl_addr} >= GLYPH_END);
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[cnt_reg[BUF_IDX_W-1:0]] <= cur_char_reg;
        end
        if (buf_re)
        begin
            buf_q_reg <= buf_mem[k_reg[BUF_IDX_W-1:0]];
        end
    end

endmodule

// File: rtl/core/gww_checker.sv
module gww_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       text_end,
    input logic       run_last,
    input logic       cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_char) && $stable(text_end)
            && $stable(run_last))
        else $error("output payload changed while stalled");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_last)
        else $error("text_end on a beat that is not the last of its item");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port back-pressured");

endmodule

bind greedy_word_wrap_core gww_checker u_gww_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (text_out.valid),
    .out_ready (text_out.ready),
    .out_char  (text_out.out_char),
    .text_end  (text_out.text_end),
    .run_last  (text_out.run_last),
    .cfg_ready (cfg.ready)
);
